/* design/hse_pkg.sv */
// Shared types and constants for the heap sort engine.
// No dependencies; every other file of the block uses this package.
package hse_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [CNT_W-1:0]        t_cnt;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;   // insert the incoming value in sorted position
        logic shl;   // shift the chain one cell toward the output
    } t_cell_ctrl;

endpackage

/* design/hse_if.sv */
// Valid/ready stream interfaces for the heap sort engine channels.
// Depends on hse_pkg for the payload types.
interface hse_in_if;
    logic          valid;
    logic          ready;
    hse_pkg::t_val value;
    logic          last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface hse_out_if;
    logic          valid;
    logic          ready;
    hse_pkg::t_val value_res;
    logic          last_res;
    logic          overflowed;

    modport source (output valid, output value_res, output last_res, output overflowed,
                    input ready);
    modport sink   (input valid, input value_res, input last_res, input overflowed,
                    output ready);
endinterface

/* design/hse_cell.sv */
// One cell of the sorting chain: holds one value of the ascending row.
// Depends on hse_pkg for the value type and the control struct.
module hse_cell (
    input  logic                i_clk,
    input  hse_pkg::t_cell_ctrl i_ctrl,
    input  hse_pkg::t_val       i_x,
    input  logic                i_occ,
    input  hse_pkg::t_val       i_left_val,
    input  logic                i_left_gt,
    input  hse_pkg::t_val       i_right_val,
    output hse_pkg::t_val       o_val,
    output logic                o_gt
);

    hse_pkg::t_val r_val;
    hse_pkg::t_val n_val;

    // an empty cell counts as larger than any value
    assign o_gt = !i_occ || (i_x < r_val);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.ins && o_gt) begin
            // first larger cell takes the new value, the rest move right
            n_val = i_left_gt ? i_left_val : i_x;
        end else if (i_ctrl.shl) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

/* design/heap_sort_engine_core.sv */
// Top level of the heap sort engine: a chain of sorting cells plus batch control.
// Depends on hse_pkg, hse_if (hse_in_if, hse_out_if) and hse_cell.
//
// Use: items arrive on i_in (value, last). Each accepted item is placed in
// sorted position in the cell chain in the same cycle, so the fill side takes
// one item per clock while i_in.ready is high. The item with last set closes
// the batch; from the next cycle the sorted values leave on o_out in ascending
// order, one per cycle while o_out.ready is high, last_res marking the final
// one. The drain walks the chain one cell per handshake, and i_in.ready is low
// while the batch drains. Up to MAX_ITEMS values are kept; further values of
// the batch are dropped and every result of that batch has overflowed set.
// When the receiver stalls, the head cell holds the current result and the
// chain stands still. Reset (i_rst_n low at a clock edge) empties the chain,
// clears the overflow flag and returns to filling; cell contents are not
// cleared, since a cell is read only once it holds a value of the batch.
module heap_sort_engine_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hse_in_if.sink           i_in,
    hse_out_if.source        o_out
);

    localparam int N = hse_pkg::MAX_ITEMS;

    hse_pkg::t_state     r_state, n_state;
    hse_pkg::t_cnt       r_count, n_count;
    logic                r_ovf, n_ovf;
    hse_pkg::t_cell_ctrl ctrl;

    hse_pkg::t_val       cell_val [N];
    logic                cell_gt  [N];

    logic                in_acc;
    logic                out_acc;
    logic                has_room;

    assign has_room = (r_count < hse_pkg::CNT_W'(N));
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_acc  = o_out.valid && o_out.ready;

    assign i_in.ready       = (r_state == hse_pkg::ST_FILL);
    assign o_out.valid      = (r_state == hse_pkg::ST_DRAIN);
    assign o_out.value_res  = cell_val[0];
    assign o_out.last_res   = (r_count == hse_pkg::CNT_W'(1));
    assign o_out.overflowed = r_ovf;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        ctrl.ins = 1'b0;
        ctrl.shl = 1'b0;
        case (r_state)
            hse_pkg::ST_FILL: begin
                if (in_acc) begin
                    if (has_room) begin
                        ctrl.ins = 1'b1;
                        n_count  = r_count + hse_pkg::CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last) begin
                        n_state = hse_pkg::ST_DRAIN;
                    end
                end
            end
            hse_pkg::ST_DRAIN: begin
                if (out_acc) begin
                    ctrl.shl = 1'b1;
                    n_count  = r_count - hse_pkg::CNT_W'(1);
                    if (r_count == hse_pkg::CNT_W'(1)) begin
                        n_state = hse_pkg::ST_FILL;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = hse_pkg::ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hse_pkg::ST_FILL;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
        hse_pkg::t_val left_val;
        logic          left_gt;
        hse_pkg::t_val right_val;
        logic          occ;

        if (i == 0) begin : g_head
            assign left_val = '0;
            assign left_gt  = 1'b0;
        end else begin : g_body
            assign left_val = cell_val[i-1];
            assign left_gt  = cell_gt[i-1];
        end

        if (i == N - 1) begin : g_tail
            assign right_val = '0;
        end else begin : g_inner
            assign right_val = cell_val[i+1];
        end

        assign occ = (hse_pkg::CNT_W'(i) < r_count);

        hse_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_x         (i_in.value),
            .i_occ       (occ),
            .i_left_val  (left_val),
            .i_left_gt   (left_gt),
            .i_right_val (right_val),
            .o_val       (cell_val[i]),
            .o_gt        (cell_gt[i])
        );
    end

endmodule

/* dv/tb_heap_sort_engine_core.sv */
// Self-checking bench for heap_sort_engine_core: feeds batches, predicts the sorted stream.
// Depends on hse_pkg, hse_if and the design top; bursty sender, stalling receiver.
`timescale 1ns / 100ps

module tb_heap_sort_engine_core;

    localparam int            WATCHDOG_LIMIT = 2000;
    localparam int            TAIL_CYCLES    = 20;
    localparam int            RANDOM_ITEMS   = 410;
    localparam hse_pkg::t_val VAL_MIN        = 32'sh8000_0000;
    localparam hse_pkg::t_val VAL_MAX        = 32'sh7fff_ffff;

    typedef struct {
        hse_pkg::t_val value;
        logic          last;
    } t_in_item;

    typedef struct {
        hse_pkg::t_val value;
        logic          last_res;
        logic          overflowed;
    } t_sorted_item;

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_STALL
    } t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hse_in_if  in_ch();
    hse_out_if out_ch();

    heap_sort_engine_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #10 i_clk = ~i_clk;

    t_in_item      pending_items[$];
    t_sorted_item  sorted_expected[$];
    hse_pkg::t_val open_batch[$];
    logic          batch_dropped;

    int       err_count;
    int       items_in;
    int       results_out;
    int       batches_closed;
    int       dropped_batches;
    int       burst_left;
    int       gap_left;
    int       rx_left;
    t_rx_mode rx_mode;
    int       idle_cycles;
    logic     timed_out;

    task automatic push_item(input hse_pkg::t_val value, input logic last);
        t_in_item it;
        it.value = value;
        it.last  = last;
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic hse_pkg::t_val pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return -1;
            4, 5:    return hse_pkg::t_val'(int'($urandom_range(0, 15)) - 8);
            default: return hse_pkg::t_val'($urandom);
        endcase
    endfunction

    task automatic push_batch(input int n);
        for (int k = 0; k < n; k++) push_item(pick_value(), k == n - 1);
    endtask

    // sender: bursts of random length, random gaps, hold until accepted
    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!(in_ch.valid && !in_ch.ready)) begin
            if (in_ch.valid) void'(pending_items.pop_front());
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                in_ch.valid <= 1'b1;
                in_ch.value <= pending_items[0].value;
                in_ch.last  <= pending_items[0].last;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: switch between open, coin-flip and mostly-stalled stretches
    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 2));
                rx_left = $urandom_range(4, 40);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:   out_ch.ready <= 1'b1;
                RX_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
                default:   out_ch.ready <= (rx_left % 8 == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : scoreboard
        int           pos;
        t_sorted_item r;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                items_in++;
                // keep the open batch in ascending order; drop once full
                if (open_batch.size() < hse_pkg::MAX_ITEMS) begin
                    pos = 0;
                    while (pos < open_batch.size() && open_batch[pos] <= in_ch.value) pos++;
                    open_batch.insert(pos, in_ch.value);
                end else begin
                    batch_dropped = 1'b1;
                end
                if (in_ch.last) begin
                    for (int k = 0; k < open_batch.size(); k++) begin
                        r.value      = open_batch[k];
                        r.last_res   = (k == open_batch.size() - 1);
                        r.overflowed = batch_dropped;
                        sorted_expected.insert(sorted_expected.size(), r);
                    end
                    batches_closed++;
                    if (batch_dropped) dropped_batches++;
                    open_batch.delete();
                    batch_dropped = 1'b0;
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                results_out++;
                if (sorted_expected.size() == 0) begin
                    $error("unexpected result: value_res=%0d last_res=%0b overflowed=%0b",
                           out_ch.value_res, out_ch.last_res, out_ch.overflowed);
                    err_count++;
                end else begin
                    r = sorted_expected.pop_front();
                    if (out_ch.value_res !== r.value) begin
                        $error("value_res: expected %0d, got %0d", r.value, out_ch.value_res);
                        err_count++;
                    end
                    if (out_ch.last_res !== r.last_res) begin
                        $error("last_res: expected %0b, got %0b", r.last_res, out_ch.last_res);
                        err_count++;
                    end
                    if (out_ch.overflowed !== r.overflowed) begin
                        $error("overflowed: expected %0b, got %0b", r.overflowed,
                               out_ch.overflowed);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
        end else begin
            idle_cycles++;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.value     = '0;
        in_ch.last      = 1'b0;
        out_ch.ready    = 1'b0;
        batch_dropped   = 1'b0;
        err_count       = 0;
        items_in        = 0;
        results_out     = 0;
        batches_closed  = 0;
        dropped_batches = 0;
        burst_left      = 1;
        gap_left        = 0;
        rx_left         = 0;
        idle_cycles     = 0;
        timed_out       = 1'b0;

        // single-value batches pass through, then a two-value batch in descending order
        push_item(VAL_MIN, 1'b1);
        push_item(VAL_MAX, 1'b1);
        push_item(VAL_MAX, 1'b0);
        push_item(VAL_MIN, 1'b1);
        // equal values side by side
        push_item(7, 1'b0);
        push_item(7, 1'b0);
        push_item(-3, 1'b0);
        push_item(7, 1'b0);
        push_item(-3, 1'b1);
        // sign boundary and alternating bit patterns
        push_item(-1, 1'b0);
        push_item(0, 1'b0);
        push_item(1, 1'b0);
        push_item(VAL_MAX, 1'b0);
        push_item(VAL_MIN, 1'b0);
        push_item(VAL_MIN + 1, 1'b0);
        push_item(VAL_MAX - 1, 1'b0);
        push_item(32'sh5555_5555, 1'b0);
        push_item(32'shaaaa_aaaa, 1'b1);
        // already ascending, then descending
        push_item(1, 1'b0);
        push_item(2, 1'b0);
        push_item(3, 1'b1);
        push_item(3, 1'b0);
        push_item(2, 1'b0);
        push_item(1, 1'b1);

        // exactly full, last value dropped, several dropped
        push_batch(hse_pkg::MAX_ITEMS);
        push_batch(hse_pkg::MAX_ITEMS + 1);
        push_batch(hse_pkg::MAX_ITEMS + 3);
        while (pending_items.size() < RANDOM_ITEMS) begin
            case ($urandom_range(0, 59))
                0:       push_batch(hse_pkg::MAX_ITEMS);
                1:       push_batch($urandom_range(hse_pkg::MAX_ITEMS + 1,
                                                   hse_pkg::MAX_ITEMS + 6));
                default: push_batch($urandom_range(1, 8));
            endcase
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!timed_out &&
               (pending_items.size() > 0 || in_ch.valid || sorted_expected.size() > 0))
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (timed_out) $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        if (sorted_expected.size() > 0) begin
            $error("sorted results never seen: %0d", sorted_expected.size());
            err_count++;
        end
        $display("sent %0d items in %0d batches, checked %0d sorted results",
                 items_in, batches_closed, results_out);
        $display("%0d batches ran past the store capacity", dropped_batches);
        if (!timed_out && err_count == 0) begin
            $display("[heap_sort_engine_core] OK");
        end else begin
            $display("[heap_sort_engine_core] ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
design/hse_pkg.sv
design/hse_if.sv
design/hse_cell.sv
design/heap_sort_engine_core.sv
dv/tb_heap_sort_engine_core.sv
